// ----- rtl/atla_pkg.sv -----
// Shared types and constants of the ANSI text line assembler.
package atla_pkg;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 7;
  localparam int GLYPH_W = 7;
  localparam int COLOR_W = 3;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;

  // Result kinds
  localparam logic KIND_GLYPH  = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  // What an accepted item asks of the result side
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_COMMIT,
    ACT_GLYPH,
    ACT_WRAP,
    ACT_TAB
  } act_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_commit;
    logic emit_glyph;
    logic emit_space;
    logic last;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    act_t act;
    logic slot_free;
    logic tab_last;
  } ctl_sts_t;

endpackage

// ----- rtl/atla_in_if.sv -----
// Input channel: function code and raw byte with valid/ready.
interface atla_in_if;
  logic                          valid;
  logic                          ready;
  logic [atla_pkg::FUNC_W-1:0]   func;
  logic [atla_pkg::BYTE_W-1:0]   byte_in;

  modport source (output valid, output func, output byte_in, input ready);
  modport sink   (input valid, input func, input byte_in, output ready);
endinterface

// ----- rtl/atla_out_if.sv -----
// Result channel: glyph writes and line commits with valid/ready.
interface atla_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [atla_pkg::COL_W-1:0]    column;
  logic [atla_pkg::GLYPH_W-1:0]  glyph;
  logic [atla_pkg::COL_W-1:0]    line_length;
  logic [atla_pkg::COLOR_W-1:0]  color;
  logic                          last;

  modport source (output valid, output kind, output column, output glyph,
                  output line_length, output color, output last, input ready);
  modport sink   (input valid, input kind, input column, input glyph,
                  input line_length, input color, input last, output ready);
endinterface

// ----- rtl/ansi_text_line_assembler_core.sv -----
// Top level of the ANSI text line assembler: turns a terminal byte stream into
// coloured line writes. Each func 0 byte is parsed for ESC [ params letter
// sequences (SGR 'm' sets the line colour), and printable bytes, mapped CP437
// box glyphs, LF, CR and TAB drive a cursor of LINE_WIDTH columns; glyph writes
// and line commits leave as transfers on out_chan, the last one of each input
// flagged by last. An input yields no result, one result, a commit then a write
// at column 0 for a glyph that wraps a full line, or for a tab one space per
// column up to the next stop of eight; no new input is taken while its results
// are pending. The single output register takes one result per cycle unless
// stalled; while stalled the controller holds, and a new input is taken in the
// same cycle as the previous final result. No clearing pass follows reset.
module ansi_text_line_assembler_core #(
  parameter int LINE_WIDTH = 118
) (
  input  logic        clk,
  input  logic        rst_n,
  atla_in_if.sink     in_chan,
  atla_out_if.source  out_chan
);
  import atla_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Controller: handshake on the input side, result sequencing
  atla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: parser, cursor and colour state, output register
  atla_dp #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_chan.func),
    .in_byte         (in_chan.byte_in),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_kind        (out_chan.kind),
    .out_column      (out_chan.column),
    .out_glyph       (out_chan.glyph),
    .out_line_length (out_chan.line_length),
    .out_color       (out_chan.color),
    .out_last        (out_chan.last)
  );

endmodule

// ----- rtl/atla_dp.sv -----
// Datapath: escape parser state, cursor, colour, byte decode and output register.
module atla_dp #(
  parameter int LINE_WIDTH = 118
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [atla_pkg::FUNC_W-1:0]   in_func,
  input  logic [atla_pkg::BYTE_W-1:0]   in_byte,
  input  atla_pkg::ctl_cmd_t            cmd,
  output atla_pkg::ctl_sts_t            sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [atla_pkg::COL_W-1:0]    out_column,
  output logic [atla_pkg::GLYPH_W-1:0]  out_glyph,
  output logic [atla_pkg::COL_W-1:0]    out_line_length,
  output logic [atla_pkg::COLOR_W-1:0]  out_color,
  output logic                          out_last
);
  import atla_pkg::*;

  localparam int CW      = $clog2(LINE_WIDTH + 1);
  localparam int PARAM_W = 10;
  localparam int PROD_W  = 14;

  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [PARAM_W-1:0] PARAM_MAX = 10'd1023;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_CSI
  } mode_t;

  function automatic logic [GLYPH_W-1:0] box_to_ascii(input logic [BYTE_W-1:0] c);
    case (c)
      8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF, 8'hFE, 8'hFD, 8'hB2: box_to_ascii = 7'h23;
      8'hB1:                                                  box_to_ascii = 7'h3A;
      8'hB0, 8'h07, 8'hF9, 8'hFA:                             box_to_ascii = 7'h2E;
      8'hC4, 8'hCD:                                           box_to_ascii = 7'h2D;
      8'hB3, 8'hBA:                                           box_to_ascii = 7'h7C;
      8'hDA, 8'hBF, 8'hC0, 8'hD9, 8'hC9, 8'hBB, 8'hC8, 8'hBC,
      8'hC3, 8'hB4, 8'hC2, 8'hC1, 8'hC5:                      box_to_ascii = 7'h2B;
      8'h1A, 8'h10:                                           box_to_ascii = 7'h3E;
      8'h11:                                                  box_to_ascii = 7'h3C;
      8'h18, 8'h1E:                                           box_to_ascii = 7'h5E;
      8'h19, 8'h1F:                                           box_to_ascii = 7'h76;
      8'hF8:                                                  box_to_ascii = 7'h6F;
      default:                                                box_to_ascii = 7'h00;
    endcase
  endfunction

  // Bright codes fold onto the normal ones; unknown codes keep the colour.
  function automatic logic [COLOR_W-1:0] sgr_color(input logic [PARAM_W-1:0] code,
                                                   input logic [COLOR_W-1:0] cur);
    logic [PARAM_W-1:0] c;
    c = (code >= 10'd90 && code <= 10'd97) ? code - 10'd60 : code;
    if (code == '0) begin
      sgr_color = '0;
    end else if (c >= 10'd30 && c <= 10'd36) begin
      sgr_color = COLOR_W'(c - 10'd29);
    end else if (c == 10'd37) begin
      sgr_color = '0;
    end else begin
      sgr_color = cur;
    end
  endfunction

  mode_t                mode_r, mode_nxt;
  logic [PARAM_W-1:0]   param_r, param_nxt;
  logic                 present_r, present_nxt;
  logic [CW-1:0]        col_r;
  logic [COLOR_W-1:0]   color_r, color_nxt;
  logic [GLYPH_W-1:0]   glyph_r;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [COL_W-1:0]     out_column_r;
  logic [GLYPH_W-1:0]   out_glyph_r;
  logic [COL_W-1:0]     out_len_r;
  logic [COLOR_W-1:0]   out_color_r;
  logic                 out_last_r;

  logic [GLYPH_W-1:0]   dec_glyph;
  logic                 glyph_ok;
  logic                 text_en;
  logic                 clr_col;
  logic                 col_full;
  logic [PROD_W-1:0]    acc;
  logic [GLYPH_W-1:0]   emit_glyph_val;
  act_t                 act;

  assign col_full  = (col_r >= CW'(LINE_WIDTH));
  assign dec_glyph = (in_byte >= CH_SPACE && in_byte <= CH_TILDE) ? in_byte[GLYPH_W-1:0]
                                                                  : box_to_ascii(in_byte);
  assign glyph_ok  = (dec_glyph != '0);
  assign acc       = {1'b0, param_r, 3'b000} + {3'b000, param_r, 1'b0} +
                     PROD_W'(in_byte - CH_ZERO);

  always_comb begin
    mode_nxt    = mode_r;
    param_nxt   = param_r;
    present_nxt = present_r;
    color_nxt   = color_r;
    clr_col     = 1'b0;
    text_en     = 1'b0;
    act         = ACT_NONE;
    case (in_func)
      FUNC_BYTE: begin
        case (mode_r)
          MODE_ESC: begin
            if (in_byte == CH_LBRK) begin
              mode_nxt    = MODE_CSI;
              param_nxt   = '0;
              present_nxt = 1'b0;
            end else begin
              mode_nxt = MODE_TEXT;
              text_en  = 1'b1;
            end
          end
          MODE_CSI: begin
            if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
              param_nxt   = (acc > PROD_W'(PARAM_MAX)) ? PARAM_MAX : acc[PARAM_W-1:0];
              present_nxt = 1'b1;
            end else if (in_byte == CH_SEMI) begin
              if (present_r) color_nxt = sgr_color(param_r, color_r);
              param_nxt   = '0;
              present_nxt = 1'b0;
            end else begin
              if (in_byte == CH_M) color_nxt = sgr_color(present_r ? param_r : '0, color_r);
              param_nxt   = '0;
              present_nxt = 1'b0;
              mode_nxt    = MODE_TEXT;
            end
          end
          default: begin
            mode_nxt = MODE_TEXT;
            text_en  = 1'b1;
          end
        endcase
      end
      FUNC_BEGIN: begin
        clr_col   = 1'b1;
        color_nxt = '0;
      end
      FUNC_END: begin
        if (col_r != '0) act = ACT_COMMIT;
      end
      default: ;
    endcase

    if (text_en) begin
      if (in_byte == CH_ESC) begin
        mode_nxt = MODE_ESC;
      end else if (in_byte == CH_LF) begin
        act = ACT_COMMIT;
      end else if (in_byte == CH_CR) begin
        clr_col = 1'b1;
      end else if (in_byte == CH_TAB) begin
        act = col_full ? ACT_NONE : ACT_TAB;
      end else if (glyph_ok) begin
        act = col_full ? ACT_WRAP : ACT_GLYPH;
      end
    end
  end

  assign sts.act       = act;
  assign sts.slot_free = !out_valid_r || out_ready;
  // Last space of a tab: the next column is a tab stop or the line end.
  assign sts.tab_last  = (col_r[2:0] == 3'b111) || (col_r == CW'(LINE_WIDTH - 1));

  assign emit_glyph_val = cmd.emit_space ? CH_SPACE[GLYPH_W-1:0]
                        : (cmd.accept ? dec_glyph : glyph_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TEXT;
      param_r     <= '0;
      present_r   <= 1'b0;
      col_r       <= '0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        mode_r    <= mode_nxt;
        param_r   <= param_nxt;
        present_r <= present_nxt;
        color_r   <= color_nxt;
      end
      if (cmd.emit_commit) begin
        col_r <= '0;
      end else if (cmd.emit_glyph || cmd.emit_space) begin
        col_r <= col_r + CW'(1);
      end else if (cmd.accept && clr_col) begin
        col_r <= '0;
      end
      if (cmd.emit_commit || cmd.emit_glyph || cmd.emit_space) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) glyph_r <= dec_glyph;
    if (cmd.emit_commit) begin
      out_kind_r   <= KIND_COMMIT;
      out_column_r <= '0;
      out_glyph_r  <= '0;
      out_len_r    <= COL_W'(col_r);
      out_color_r  <= color_r;
      out_last_r   <= cmd.last;
    end else if (cmd.emit_glyph || cmd.emit_space) begin
      out_kind_r   <= KIND_GLYPH;
      out_column_r <= COL_W'(col_r);
      out_glyph_r  <= emit_glyph_val;
      out_len_r    <= '0;
      out_color_r  <= color_r;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_column      = out_column_r;
  assign out_glyph       = out_glyph_r;
  assign out_line_length = out_len_r;
  assign out_color       = out_color_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/atla_ctrl.sv -----
// Controller: accepts items and sequences the results each one causes.
module atla_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  atla_pkg::ctl_sts_t  sts,
  output atla_pkg::ctl_cmd_t  cmd
);
  import atla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRAP,
    S_TAB
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE) && sts.slot_free;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          case (sts.act)
            ACT_COMMIT: begin
              cmd.emit_commit = 1'b1;
              cmd.last        = 1'b1;
            end
            ACT_GLYPH: begin
              cmd.emit_glyph = 1'b1;
              cmd.last       = 1'b1;
            end
            ACT_WRAP: begin
              cmd.emit_commit = 1'b1;
              state_nxt       = S_WRAP;
            end
            ACT_TAB: begin
              cmd.emit_space = 1'b1;
              cmd.last       = sts.tab_last;
              if (!sts.tab_last) state_nxt = S_TAB;
            end
            default: ;
          endcase
        end
      end
      S_WRAP: begin
        if (sts.slot_free) begin
          cmd.emit_glyph = 1'b1;
          cmd.last       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_TAB: begin
        if (sts.slot_free) begin
          cmd.emit_space = 1'b1;
          cmd.last       = sts.tab_last;
          if (sts.tab_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input taken while results of an earlier item are pending");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_commit, cmd.emit_glyph, cmd.emit_space}))
    else $error("more than one result loaded in one cycle");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_commit || cmd.emit_glyph || cmd.emit_space) |-> sts.slot_free)
    else $error("result loaded over an untaken result");

  a_wrap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRAP && sts.slot_free) |=> (state_r == S_IDLE))
    else $error("wrapped glyph not written after its commit");

  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (in_valid && state_r == S_IDLE))
    else $error("item accepted without a valid transfer");
`endif

endmodule

// ----- dv/ansi_text_line_assembler_core_test.sv -----
// Self-checking regression of the ANSI text line assembler: directed and random byte streams.
module ansi_text_line_assembler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import atla_pkg::*;

  localparam int LINE_COLS    = 118;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 100;

  // func code the block ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Bytes with a meaning of their own in the stream
  localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CSI  = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] CH_SEP  = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CH_SGR  = 8'h6D;  // 'm'
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

  localparam int unsigned PARAM_CAP = 1023;

  typedef enum logic [1:0] {
    SCAN_TEXT,
    SCAN_ESC,
    SCAN_CSI
  } scan_t;

  typedef struct packed {
    logic               kind;
    logic [COL_W-1:0]   column;
    logic [GLYPH_W-1:0] glyph;
    logic [COL_W-1:0]   line_length;
    logic [COLOR_W-1:0] color;
    logic               last;
  } line_event_t;

  logic clk;
  logic rst_n;

  atla_in_if  in_chan ();
  atla_out_if out_chan ();

  ansi_text_line_assembler_core #(
    .LINE_WIDTH (LINE_COLS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Mirror of the assembler state, advanced once per accepted transfer
  scan_t              scan_mode   = SCAN_TEXT;
  int unsigned        sgr_value   = 0;
  bit                 sgr_seen    = 1'b0;
  int unsigned        cursor      = 0;
  logic [COLOR_W-1:0] pen         = '0;
  int                 batch_count = 0;

  line_event_t pending_line_events[$];
  line_event_t oldest_event;

  int idle_pct    = 12;
  int sent_items  = 0;
  int fail_count  = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line prediction
  // ---------------------------------------------------------------------------

  // SGR code to palette index; bright codes fold onto the normal ones, and
  // anything unknown (every code of 100 or more too) keeps the current pen.
  function automatic logic [COLOR_W-1:0] sgr_to_pen(int unsigned code,
                                                    logic [COLOR_W-1:0] cur);
    int unsigned c;
    c = code;
    if (c == 0) return '0;
    if (c >= 90 && c <= 97) c = c - 60;
    if (c >= 30 && c <= 36) return COLOR_W'(c - 29);
    if (c == 37) return '0;
    return cur;
  endfunction

  // CP437 box, shade and arrow glyphs with an ASCII stand-in; 0 means drop
  function automatic logic [GLYPH_W-1:0] cp437_stand_in(logic [BYTE_W-1:0] b);
    case (b)
      8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF, 8'hFE, 8'hFD, 8'hB2: return "#";
      8'hB1:                                                 return ":";
      8'hB0, 8'h07, 8'hF9, 8'hFA:                            return ".";
      8'hC4, 8'hCD:                                          return "-";
      8'hB3, 8'hBA:                                          return "|";
      8'hDA, 8'hBF, 8'hC0, 8'hD9, 8'hC9, 8'hBB, 8'hC8, 8'hBC,
      8'hC3, 8'hB4, 8'hC2, 8'hC1, 8'hC5:                     return "+";
      8'h1A, 8'h10:                                          return ">";
      8'h11:                                                 return "<";
      8'h18, 8'h1E:                                          return "^";
      8'h19, 8'h1F:                                          return "v";
      8'hF8:                                                 return "o";
      default:                                               return '0;
    endcase
  endfunction

  function automatic void push_event(logic kind, int unsigned col,
                                     logic [GLYPH_W-1:0] glyph, int unsigned len);
    line_event_t ev;
    ev.kind        = kind;
    ev.column      = COL_W'(col);
    ev.glyph       = glyph;
    ev.line_length = COL_W'(len);
    ev.color       = pen;
    ev.last        = 1'b0;
    pending_line_events.push_back(ev);
    batch_count++;
  endfunction

  function automatic void commit_line();
    push_event(KIND_COMMIT, 0, '0, cursor);
    cursor = 0;
  endfunction

  // Plain text handling, outside any escape sequence
  function automatic void text_byte(logic [BYTE_W-1:0] b);
    int unsigned        tab_stop;
    logic [GLYPH_W-1:0] g;
    if (b == CH_ESC) begin
      scan_mode = SCAN_ESC;
      return;
    end
    if (b == CH_LF) begin
      commit_line();
      return;
    end
    if (b == CH_CR) begin
      cursor = 0;
      return;
    end
    if (b == CH_TAB) begin
      // pad to the next stop of eight, but never past the line end
      tab_stop = (cursor + 8) & ~32'd7;
      while (cursor < tab_stop && cursor < LINE_COLS) begin
        push_event(KIND_GLYPH, cursor, CH_SPACE[GLYPH_W-1:0], 0);
        cursor++;
      end
      return;
    end
    if (b < CH_SPACE || b > CH_TILDE) g = cp437_stand_in(b);
    else g = b[GLYPH_W-1:0];
    if (g == '0) return;
    // a full line commits before the glyph lands at column 0
    if (cursor >= LINE_COLS) commit_line();
    push_event(KIND_GLYPH, cursor, g, 0);
    cursor++;
  endfunction

  function automatic void predict_line_events(logic [FUNC_W-1:0] f,
                                              logic [BYTE_W-1:0] b);
    batch_count = 0;
    case (f)
      FUNC_BEGIN: begin
        // parse state survives a capture boundary
        cursor = 0;
        pen    = '0;
      end
      FUNC_END: begin
        if (cursor > 0) commit_line();
      end
      FUNC_BYTE: begin
        case (scan_mode)
          SCAN_ESC: begin
            if (b == CH_CSI) begin
              scan_mode = SCAN_CSI;
              sgr_value = 0;
              sgr_seen  = 1'b0;
            end else begin
              scan_mode = SCAN_TEXT;
              text_byte(b);
            end
          end
          SCAN_CSI: begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              sgr_value = sgr_value * 10 + (b - CH_ZERO);
              if (sgr_value > PARAM_CAP) sgr_value = PARAM_CAP;
              sgr_seen = 1'b1;
            end else if (b == CH_SEP) begin
              if (sgr_seen) pen = sgr_to_pen(sgr_value, pen);
              sgr_value = 0;
              sgr_seen  = 1'b0;
            end else begin
              // any other byte closes the sequence and is swallowed
              if (b == CH_SGR) pen = sgr_to_pen(sgr_seen ? sgr_value : 0, pen);
              sgr_value = 0;
              sgr_seen  = 1'b0;
              scan_mode = SCAN_TEXT;
            end
          end
          default: text_byte(b);
        endcase
      end
      default: ;
    endcase
    if (batch_count > 0) pending_line_events[pending_line_events.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every result transfer against the oldest predicted event
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_line_events.size() == 0) begin
        $error("result transfer with nothing predicted: kind %0d column %0d glyph %0d",
               out_chan.kind, out_chan.column, out_chan.glyph);
        fail_count++;
      end else begin
        oldest_event = pending_line_events.pop_front();
        check_field("kind", oldest_event.kind, out_chan.kind);
        check_field("column", oldest_event.column, out_chan.column);
        check_field("glyph", oldest_event.glyph, out_chan.glyph);
        check_field("line_length", oldest_event.line_length, out_chan.line_length);
        check_field("color", oldest_event.color, out_chan.color);
        check_field("last", oldest_event.last, out_chan.last);
      end
    end
  end

  // Result side back-pressure at the shared idle rate
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ansi_text_line_assembler_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one item, wait for its transfer, then predict what it causes.
  // Valid stays high after the transfer; the next call replaces the item or drops it, as does a drain.
  task automatic feed_terminal(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.func    <= f;
    in_chan.byte_in <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_line_events(f, b);
    if (f != FUNC_UNUSED) sent_items++;
  endtask

  task automatic feed_number(input int unsigned value);
    string digits;
    digits = $sformatf("%0d", value);
    for (int i = 0; i < digits.len(); i++) feed_terminal(FUNC_BYTE, digits[i]);
  endtask

  // Hold the input idle until every predicted event has come out
  task automatic drain_lines();
    in_chan.valid <= 1'b0;
    while (pending_line_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Printable extremes, every CP437 stand-in class, dropped bytes, the line
  // controls, both capture edges and the unused func code
  task automatic test_text_and_controls();
    logic [BYTE_W-1:0] box_codes[11] = '{8'hDB, 8'hB1, 8'hB0, 8'hC4, 8'hB3, 8'hDA,
                                         8'h1A, 8'h11, 8'h18, 8'h19, 8'hF8};
    feed_terminal(FUNC_BEGIN, 8'hFF);
    feed_terminal(FUNC_BYTE, CH_SPACE);
    feed_terminal(FUNC_BYTE, CH_TILDE);
    feed_terminal(FUNC_BYTE, 8'h00);
    feed_terminal(FUNC_BYTE, 8'h7F);
    feed_terminal(FUNC_BYTE, 8'hFF);
    foreach (box_codes[i]) feed_terminal(FUNC_BYTE, box_codes[i]);
    feed_terminal(FUNC_BYTE, CH_CR);
    feed_terminal(FUNC_BYTE, CH_TAB);
    feed_terminal(FUNC_BYTE, CH_LF);
    feed_terminal(FUNC_BYTE, CH_LF);        // empty line still commits
    feed_terminal(FUNC_END, 8'h00);         // empty line: nothing
    feed_terminal(FUNC_BYTE, "q");
    feed_terminal(FUNC_UNUSED, 8'hA5);
    feed_terminal(FUNC_END, 8'h00);
    drain_lines();
  endtask

  // Escape parsing: lone ESC, ESC ESC, separators, saturation, codes of 100
  // and more, bare 'm', non-SGR finals, and a capture boundary inside CSI
  task automatic test_escape_sequences();
    feed_terminal(FUNC_BYTE, CH_ESC);
    feed_terminal(FUNC_BYTE, "x");
    feed_terminal(FUNC_BYTE, CH_ESC);
    feed_terminal(FUNC_BYTE, CH_ESC);
    feed_terminal(FUNC_BYTE, CH_CSI);
    feed_number(31);
    feed_terminal(FUNC_BYTE, CH_SGR);
    feed_terminal(FUNC_BYTE, "a");
    feed_terminal(FUNC_BYTE, CH_ESC);
    feed_terminal(FUNC_BYTE, CH_CSI);
    feed_number(92);
    feed_terminal(FUNC_BYTE, CH_SEP);
    feed_number(120);
    feed_terminal(FUNC_BYTE, CH_SEP);
    feed_terminal(FUNC_BYTE, CH_SGR);       // bare 'm' after a separator
    feed_terminal(FUNC_BYTE, "b");
    feed_terminal(FUNC_BYTE, CH_ESC);
    feed_terminal(FUNC_BYTE, CH_CSI);
    feed_number(34);
    feed_terminal(FUNC_BYTE, CH_SEP);
    feed_number(99999);                     // saturates, keeps the pen
    feed_terminal(FUNC_BYTE, "H");
    feed_terminal(FUNC_BYTE, CH_ESC);
    feed_terminal(FUNC_BYTE, CH_CSI);
    feed_terminal(FUNC_BEGIN, 8'h00);
    feed_number(97);
    feed_terminal(FUNC_BYTE, CH_SGR);
    feed_terminal(FUNC_BYTE, "c");
    feed_terminal(FUNC_BYTE, CH_LF);
    drain_lines();
  endtask

  // Fill a line with tabs, tab at the full line, then wrap on a glyph
  task automatic test_full_line();
    feed_terminal(FUNC_BEGIN, 8'h00);
    repeat (16) feed_terminal(FUNC_BYTE, CH_TAB);
    feed_terminal(FUNC_BYTE, "Z");
    feed_terminal(FUNC_END, 8'h00);
    drain_lines();
  endtask

  function automatic int unsigned pick_sgr_code();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2, 3: return 30 + $urandom_range(0, 7);
      4, 5, 6: return 90 + $urandom_range(0, 7);
      7:       return $urandom_range(0, 99);
      8:       return $urandom_range(100, PARAM_CAP);
      default: return $urandom_range(PARAM_CAP + 1, 99999);
    endcase
  endfunction

  // Capture boundaries are rare; the unused code rarer still
  function automatic logic [FUNC_W-1:0] FUNC_Width_pick();
    case ($urandom_range(0, 4))
      0, 1:    return FUNC_BEGIN;
      2, 3:    return FUNC_END;
      default: return FUNC_UNUSED;
    endcase
  endfunction

  // Mostly well-formed text with SGR sequences, plus noise and broken escapes.
  // Start with a stretch of no idling, then idle at the usual rate.
  task automatic test_random_stream();
    int first_item;
    int n;
    first_item = sent_items;
    idle_pct = 0;
    while (sent_items < first_item + RANDOM_ITEMS) begin
      if (sent_items >= first_item + 60) idle_pct = 12;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          n = $urandom_range(1, 14);
          repeat (n) feed_terminal(FUNC_BYTE, BYTE_W'($urandom_range(CH_SPACE, CH_TILDE)));
        end
        7, 8, 9: begin
          feed_terminal(FUNC_BYTE, CH_ESC);
          feed_terminal(FUNC_BYTE, CH_CSI);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) begin
            if (i > 0) feed_terminal(FUNC_BYTE, CH_SEP);
            feed_number(pick_sgr_code());
          end
          if ($urandom_range(0, 4) == 0)
            feed_terminal(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
          else
            feed_terminal(FUNC_BYTE, CH_SGR);
        end
        10, 11, 12: feed_terminal(FUNC_BYTE, CH_TAB);
        13:         feed_terminal(FUNC_BYTE, ($urandom_range(0, 2) == 0) ? CH_LF : CH_CR);
        14, 15:     feed_terminal(FUNC_BYTE, BYTE_W'($urandom_range(8'h80, 8'hFF)));
        16:         feed_terminal(FUNC_Width_pick(), BYTE_W'($urandom_range(0, 255)));
        17:         feed_terminal(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
        default: begin
          // broken escape: ESC followed by anything
          feed_terminal(FUNC_BYTE, CH_ESC);
          feed_terminal(FUNC_BYTE, BYTE_W'($urandom_range(0, 255)));
        end
      endcase
    end
    drain_lines();
  endtask

  initial begin
    in_chan.valid   <= 1'b0;
    in_chan.func    <= FUNC_BYTE;
    in_chan.byte_in <= '0;
    rst_n           <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_text_and_controls();
    test_escape_sequences();
    test_full_line();
    test_random_stream();

    if (fail_count == 0) begin
      $display("ansi_text_line_assembler_core regression: pass");
    end else begin
      $display("ansi_text_line_assembler_core regression: fail");
    end
    $finish;
  end

endmodule
